// ===== hw/rtl/owb_pkg.sv =====
// ----------------------------------------------------------------------------
// owb_pkg
// Shared types and constants for the 1-Wire bus master: phase codes,
// timing register indexes, reset values and the item structures.
// ----------------------------------------------------------------------------
package owb_pkg;

   // widths of the timing registers and the tick counter
   localparam int CFG_WIDTH     = 16;
   localparam int COUNT_WIDTH   = CFG_WIDTH;
   localparam int BITS_PER_BYTE = 8;
   localparam int BIT_IDX_WIDTH = $clog2(BITS_PER_BYTE);
   localparam int NUM_REGS      = 7;
   localparam int REG_IDX_WIDTH = $clog2(NUM_REGS + 1);

   localparam logic [BIT_IDX_WIDTH-1:0] LAST_BIT = BIT_IDX_WIDTH'(BITS_PER_BYTE - 1);

   // timing register indexes
   typedef enum logic [REG_IDX_WIDTH-1:0] {
      REG_RESET_LOW    = 3'd0,
      REG_PRESENCE     = 3'd1,
      REG_RESET_REC    = 3'd2,
      REG_WRITE_LOW    = 3'd3,
      REG_WRITE_HOLD   = 3'd4,
      REG_READ_LOW     = 3'd5,
      REG_READ_REC     = 3'd6
   } reg_idx_type;

   // command codes
   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_RESET = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   // bus phases
   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_RST_LOW   = 3'd1,
      PH_PRES_WAIT = 3'd2,
      PH_RST_REC   = 3'd3,
      PH_WR_LOW    = 3'd4,
      PH_WR_HOLD   = 3'd5,
      PH_RD_LOW    = 3'd6,
      PH_RD_REC    = 3'd7
   } phase_type;

   typedef logic [CFG_WIDTH-1:0] cfg_array_type [NUM_REGS];

   localparam cfg_array_type CFG_RESET_VALS = '{
      CFG_WIDTH'(500), CFG_WIDTH'(70), CFG_WIDTH'(500), CFG_WIDTH'(10),
      CFG_WIDTH'(50), CFG_WIDTH'(10), CFG_WIDTH'(50)
   };

   // one tick item
   typedef struct packed {
      logic [1:0]               operation;
      logic [BITS_PER_BYTE-1:0] data_byte;
      logic                     line_level;
   } owb_item_type;

   // one result item
   typedef struct packed {
      logic                     drive_low;
      logic                     busy_res;
      logic                     done_res;
      logic                     presence;
      logic [BITS_PER_BYTE-1:0] read_data;
   } owb_result_type;

endpackage

// ===== hw/rtl/owb_regs.sv =====
// ----------------------------------------------------------------------------
// owb_regs
// Timing register file, written over the csr channel.
// ----------------------------------------------------------------------------
module owb_regs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [owb_pkg::REG_IDX_WIDTH-1:0]    csr_index,
   input  logic [owb_pkg::CFG_WIDTH-1:0]        csr_wdata,
   output owb_pkg::cfg_array_type               regs
);

   owb_pkg::cfg_array_type regs_ff;

   // always ready, indexes beyond the list are dropped
   assign csr_ready = 1'b1;
   assign regs      = regs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= owb_pkg::CFG_RESET_VALS;
      end else if (csr_valid && csr_ready) begin
         for (int i = 0; i < owb_pkg::NUM_REGS; i++) begin
            if (csr_index == owb_pkg::REG_IDX_WIDTH'(i)) begin
               regs_ff[i] <= csr_wdata;
            end
         end
      end
   end

endmodule

// ===== hw/rtl/owb_core.sv =====
// ----------------------------------------------------------------------------
// owb_core
// Bus phase sequencer: advances the phase state and tick counter by one
// tick per step and forms the result item for the new state.
// ----------------------------------------------------------------------------
module owb_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  owb_pkg::owb_item_type    item,
   input  owb_pkg::cfg_array_type   regs,
   output owb_pkg::owb_result_type  result
);

   owb_pkg::phase_type                     phase_ff, phase_in;
   logic [owb_pkg::COUNT_WIDTH-1:0]        tick_ff, tick_in;
   logic [owb_pkg::BIT_IDX_WIDTH-1:0]      bit_idx_ff, bit_idx_in;
   logic [owb_pkg::BITS_PER_BYTE-1:0]      shift_ff, shift_in;
   logic                                   presence_ff, presence_in;
   logic [owb_pkg::BITS_PER_BYTE-1:0]      rdata_ff, rdata_in;
   logic [owb_pkg::CFG_WIDTH-1:0]          limit;
   logic                                   done;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= owb_pkg::PH_IDLE;
         tick_ff     <= '0;
         bit_idx_ff  <= '0;
         shift_ff    <= '0;
         presence_ff <= 1'b0;
         rdata_ff    <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         tick_ff     <= tick_in;
         bit_idx_ff  <= bit_idx_in;
         shift_ff    <= shift_in;
         presence_ff <= presence_in;
         rdata_ff    <= rdata_in;
      end
   end

   // phase length for the current phase
   always_comb begin
      unique case (phase_ff)
         owb_pkg::PH_RST_LOW:   limit = regs[owb_pkg::REG_RESET_LOW];
         owb_pkg::PH_PRES_WAIT: limit = regs[owb_pkg::REG_PRESENCE];
         owb_pkg::PH_RST_REC:   limit = regs[owb_pkg::REG_RESET_REC];
         owb_pkg::PH_WR_LOW:    limit = regs[owb_pkg::REG_WRITE_LOW];
         owb_pkg::PH_WR_HOLD:   limit = regs[owb_pkg::REG_WRITE_HOLD];
         owb_pkg::PH_RD_LOW:    limit = regs[owb_pkg::REG_READ_LOW];
         owb_pkg::PH_RD_REC:    limit = regs[owb_pkg::REG_READ_REC];
         default:               limit = '0;
      endcase
   end

   // next state for one tick
   always_comb begin
      phase_in    = phase_ff;
      tick_in     = tick_ff;
      bit_idx_in  = bit_idx_ff;
      shift_in    = shift_ff;
      presence_in = presence_ff;
      rdata_in    = rdata_ff;
      done        = 1'b0;

      if (phase_ff == owb_pkg::PH_IDLE) begin
         // start a command
         unique case (owb_pkg::op_type'(item.operation))
            owb_pkg::OP_RESET: begin
               phase_in   = owb_pkg::PH_RST_LOW;
               tick_in    = owb_pkg::COUNT_WIDTH'(1);
               bit_idx_in = '0;
            end
            owb_pkg::OP_WRITE: begin
               phase_in   = owb_pkg::PH_WR_LOW;
               tick_in    = owb_pkg::COUNT_WIDTH'(1);
               bit_idx_in = '0;
               shift_in   = item.data_byte;
            end
            owb_pkg::OP_READ: begin
               phase_in   = owb_pkg::PH_RD_LOW;
               tick_in    = owb_pkg::COUNT_WIDTH'(1);
               bit_idx_in = '0;
               shift_in   = '0;
            end
            default: ;
         endcase
      end else if (tick_ff < limit) begin
         tick_in = tick_ff + owb_pkg::COUNT_WIDTH'(1);
      end else begin
         // phase over, move on
         tick_in = owb_pkg::COUNT_WIDTH'(1);
         unique case (phase_ff)
            owb_pkg::PH_RST_LOW: phase_in = owb_pkg::PH_PRES_WAIT;
            owb_pkg::PH_PRES_WAIT: begin
               presence_in = ~item.line_level;
               phase_in    = owb_pkg::PH_RST_REC;
            end
            owb_pkg::PH_RST_REC: begin
               phase_in = owb_pkg::PH_IDLE;
               tick_in  = '0;
               done     = 1'b1;
            end
            owb_pkg::PH_WR_LOW: phase_in = owb_pkg::PH_WR_HOLD;
            owb_pkg::PH_WR_HOLD: begin
               if (bit_idx_ff == owb_pkg::LAST_BIT) begin
                  phase_in = owb_pkg::PH_IDLE;
                  tick_in  = '0;
                  done     = 1'b1;
               end else begin
                  bit_idx_in = bit_idx_ff + 1'b1;
                  phase_in   = owb_pkg::PH_WR_LOW;
               end
            end
            owb_pkg::PH_RD_LOW: begin
               // sample the bit straight after the low time
               shift_in[bit_idx_ff] = shift_ff[bit_idx_ff] | item.line_level;
               phase_in             = owb_pkg::PH_RD_REC;
            end
            owb_pkg::PH_RD_REC: begin
               if (bit_idx_ff == owb_pkg::LAST_BIT) begin
                  rdata_in = shift_ff;
                  phase_in = owb_pkg::PH_IDLE;
                  tick_in  = '0;
                  done     = 1'b1;
               end else begin
                  bit_idx_in = bit_idx_ff + 1'b1;
                  phase_in   = owb_pkg::PH_RD_LOW;
               end
            end
            default: ;
         endcase
      end
   end

   // result item from the new state
   always_comb begin
      case (phase_in)
         owb_pkg::PH_RST_LOW,
         owb_pkg::PH_WR_LOW,
         owb_pkg::PH_RD_LOW:  result.drive_low = 1'b1;
         owb_pkg::PH_WR_HOLD: result.drive_low = ~shift_in[bit_idx_in];
         default:             result.drive_low = 1'b0;
      endcase
      result.busy_res  = (phase_in != owb_pkg::PH_IDLE);
      result.done_res  = done;
      result.presence  = presence_in;
      result.read_data = rdata_in;
   end

endmodule

// ===== hw/rtl/one_wire_bus_master.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master
// 1-Wire bus master: each item is one time tick; produces one result item
// per tick with the drive-low level, busy, done, presence and read byte.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake             payload
//   req_     in         req_valid/req_stall   operation, data_byte, line_level
//   rsp_     out        rsp_valid/rsp_stall   drive_low, busy_res, done_res,
//                                             presence, read_data
//   csr_     in         csr_valid/csr_ready   csr_index, csr_wdata
//
// One item a cycle while rsp_ is not stalled: an item is held in the
// input register, the sequencer steps on it and its result lands in
// the result register.
// Synchronous reset returns the sequencer to idle and the timing
// registers to their default tick counts.
// A stall on rsp_ holds the result register and backs up into req_stall
// once the input register is full.
// ----------------------------------------------------------------------------
module one_wire_bus_master (
   input  logic                                   clock,
   input  logic                                   reset,
   // tick items
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_operation,
   input  logic [owb_pkg::BITS_PER_BYTE-1:0]      req_data_byte,
   input  logic                                   req_line_level,
   // result items
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_drive_low,
   output logic                                   rsp_busy_res,
   output logic                                   rsp_done_res,
   output logic                                   rsp_presence,
   output logic [owb_pkg::BITS_PER_BYTE-1:0]      rsp_read_data,
   // register writes
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [owb_pkg::REG_IDX_WIDTH-1:0]      csr_index,
   input  logic [owb_pkg::CFG_WIDTH-1:0]          csr_wdata
);

   owb_pkg::cfg_array_type   regs;
   owb_pkg::owb_item_type    in_item_ff;
   logic                     in_valid_ff, in_valid_in;
   owb_pkg::owb_result_type  result;
   owb_pkg::owb_result_type  rsp_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     step;
   logic                     req_accept;

   owb_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .regs      (regs)
   );

   owb_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .regs   (regs),
      .result (result)
   );

   // handshake: step when the result register is free or being emptied
   assign step        = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !step;
   assign req_accept  = req_valid && !req_stall;
   assign in_valid_in = req_accept || (in_valid_ff && !step);
   assign rsp_valid_in = step || (rsp_valid_ff && rsp_stall);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.operation  <= req_operation;
         in_item_ff.data_byte  <= req_data_byte;
         in_item_ff.line_level <= req_line_level;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive_low = rsp_ff.drive_low;
   assign rsp_busy_res  = rsp_ff.busy_res;
   assign rsp_done_res  = rsp_ff.done_res;
   assign rsp_presence  = rsp_ff.presence;
   assign rsp_read_data = rsp_ff.read_data;

endmodule
